// ----- rtl/cesd_pkg.sv -----
// Shared types and constants for the C escape sequence decoder.
// No dependencies; used by every module in rtl/.
`default_nettype none

package cesd_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_OCT   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_9         = 8'h39;

  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_TAB = 8'd9;

  localparam logic [1:0] OCT_LAST_COUNT = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       octal_warning;
    logic       last_of_run;
    logic       last_of_string;
  } result_t;

  // one queue entry: all results caused by one input beat
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= CH_0) && (c <= CH_9);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    hex_val = r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cesd_front.sv -----
// Front end: accepts input beats, tracks escape state, builds queue entries.
// Depends on cesd_pkg.
`default_nettype none

module cesd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_string,
  output logic                  push,
  output cesd_pkg::entry_t      push_entry
);

  cesd_pkg::mode_t mode, mode_next;
  logic [1:0]      digit_count, digit_count_next;
  logic [7:0]      acc, acc_next;
  logic            warn, warn_next;

  logic            e0, e1;
  logic [7:0]      b0, b1;
  logic            w0;
  logic            plain_esc;
  logic [4:0]      hv;
  logic [7:0]      oct_acc;
  logic            oct_warn;

  always_comb begin
    plain_esc        = (in_byte == cesd_pkg::CH_BACKSLASH) && !end_of_string;
    hv               = cesd_pkg::hex_val(in_byte);
    oct_acc          = {acc[4:0], 3'b000} + {4'd0, in_byte[3:0]};
    oct_warn         = warn | (in_byte > cesd_pkg::CH_7);
    mode_next        = mode;
    digit_count_next = digit_count;
    acc_next         = acc;
    warn_next        = warn;
    e0 = 1'b0;
    e1 = 1'b0;
    b0 = in_byte;
    b1 = in_byte;
    w0 = 1'b0;
    unique case (mode)
      cesd_pkg::MODE_PLAIN: begin
        if (plain_esc) begin
          mode_next = cesd_pkg::MODE_ESC;
        end else begin
          e0 = 1'b1;
        end
      end
      cesd_pkg::MODE_ESC: begin
        mode_next = cesd_pkg::MODE_PLAIN;
        e0 = 1'b1;
        if (in_byte == cesd_pkg::CH_B) begin
          b0 = cesd_pkg::CODE_BS;
        end else if (in_byte == cesd_pkg::CH_F) begin
          b0 = cesd_pkg::CODE_FF;
        end else if (in_byte == cesd_pkg::CH_N) begin
          b0 = cesd_pkg::CODE_LF;
        end else if (in_byte == cesd_pkg::CH_R) begin
          b0 = cesd_pkg::CODE_CR;
        end else if (in_byte == cesd_pkg::CH_T) begin
          b0 = cesd_pkg::CODE_TAB;
        end else if (in_byte == cesd_pkg::CH_X) begin
          mode_next = cesd_pkg::MODE_HEX;
          acc_next  = 8'd0;
          e0 = end_of_string;
          b0 = 8'd0;
        end else if (cesd_pkg::is_dec(in_byte)) begin
          mode_next        = cesd_pkg::MODE_OCT;
          digit_count_next = 2'd1;
          acc_next         = {4'd0, in_byte[3:0]};
          warn_next        = in_byte > cesd_pkg::CH_7;
          e0 = end_of_string;
          b0 = {4'd0, in_byte[3:0]};
          w0 = in_byte > cesd_pkg::CH_7;
        end
      end
      cesd_pkg::MODE_HEX: begin
        if (hv[4]) begin
          acc_next = {acc[3:0], hv[3:0]};
          e0 = end_of_string;
          b0 = {acc[3:0], hv[3:0]};
        end else begin
          e0 = 1'b1;
          b0 = acc;
          acc_next  = 8'd0;
          if (plain_esc) begin
            mode_next = cesd_pkg::MODE_ESC;
          end else begin
            mode_next = cesd_pkg::MODE_PLAIN;
            e1 = 1'b1;
          end
        end
      end
      cesd_pkg::MODE_OCT: begin
        if (cesd_pkg::is_dec(in_byte)) begin
          acc_next         = oct_acc;
          warn_next        = oct_warn;
          digit_count_next = digit_count + 2'd1;
          if (digit_count == cesd_pkg::OCT_LAST_COUNT || end_of_string) begin
            e0 = 1'b1;
            b0 = oct_acc;
            w0 = oct_warn;
            mode_next        = cesd_pkg::MODE_PLAIN;
            digit_count_next = 2'd0;
            acc_next         = 8'd0;
            warn_next        = 1'b0;
          end
        end else begin
          e0 = 1'b1;
          b0 = acc;
          w0 = warn;
          digit_count_next = 2'd0;
          acc_next         = 8'd0;
          warn_next        = 1'b0;
          if (plain_esc) begin
            mode_next = cesd_pkg::MODE_ESC;
          end else begin
            mode_next = cesd_pkg::MODE_PLAIN;
            e1 = 1'b1;
          end
        end
      end
      default: begin
        mode_next = cesd_pkg::MODE_PLAIN;
      end
    endcase
    if (end_of_string) begin
      mode_next        = cesd_pkg::MODE_PLAIN;
      digit_count_next = 2'd0;
      acc_next         = 8'd0;
      warn_next        = 1'b0;
    end
  end

  always_comb begin
    push                             = in_fire && e0;
    push_entry.two                   = e1;
    push_entry.first.out_byte        = b0;
    push_entry.first.octal_warning   = w0;
    push_entry.first.last_of_run     = !e1;
    push_entry.first.last_of_string  = !e1 && end_of_string;
    push_entry.second.out_byte       = b1;
    push_entry.second.octal_warning  = 1'b0;
    push_entry.second.last_of_run    = 1'b1;
    push_entry.second.last_of_string = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cesd_pkg::MODE_PLAIN;
      digit_count <= 2'd0;
      acc         <= 8'd0;
      warn        <= 1'b0;
    end else if (in_fire) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      acc         <= acc_next;
      warn        <= warn_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cesd_fifo.sv -----
// Short queue of decoded entries between front and back end.
// Depends on cesd_pkg.
`default_nettype none

module cesd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cesd_pkg::entry_t push_entry,
  input  wire logic             pop,
  output cesd_pkg::entry_t      head,
  output logic                  empty,
  output logic                  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  cesd_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign empty = (count == '0);
  assign full  = (count == DEPTH_C);
  assign head  = mem[rd_ptr];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cesd_back.sv -----
// Back end: drains queue entries into the output register, one result a beat while the output is not stalled.
// Depends on cesd_pkg.
`default_nettype none

module cesd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cesd_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cesd_pkg::result_t     out_res
);

  logic              pending;
  cesd_pkg::result_t pend_res;
  logic              load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pending && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else begin
        out_valid <= !empty;
        pending   <= !empty && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        out_res <= pend_res;
      end else begin
        out_res  <= head.first;
        pend_res <= head.second;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/c_escape_sequence_decoder_top.sv -----
// Top level of the C escape sequence decoder: front end, queue, back end.
// Depends on cesd_pkg, cesd_front, cesd_fifo, cesd_back.
//
//   channel | signals                                      | direction
//   in      | in_valid, in_stall, in_byte, end_of_string   | into block
//   out     | out_valid, out_stall, out_byte,              | out of block
//           | octal_warning, last_of_run, last_of_string   |
//
// One input beat per cycle is accepted while the queue has room.
// A result is written into the queue with its input beat and then loaded into the output register.
// An input that causes two results holds the back end until both have been sent;
// the queue absorbs this, stalling the input only when it fills.
// Synchronous reset returns to plain text with the queue and output empty.
`default_nettype none

module c_escape_sequence_decoder_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            octal_warning,
  output logic            last_of_run,
  output logic            last_of_string
);

  logic              in_fire;
  logic              push, pop, empty, full;
  cesd_pkg::entry_t  push_entry, head;
  cesd_pkg::result_t out_res;

  assign in_stall = full;
  assign in_fire  = in_valid && !in_stall;

  cesd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .push_entry    (push_entry)
  );

  cesd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  cesd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte       = out_res.out_byte;
  assign octal_warning  = out_res.octal_warning;
  assign last_of_run    = out_res.last_of_run;
  assign last_of_string = out_res.last_of_string;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for c_escape_sequence_decoder_top: C escape strings go in
// as byte beats, and each decoded byte is checked against an in-bench decoder.
// Depends on cesd_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    logic       drain;  // hold this beat until all decoded bytes have come
  } char_beat_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       octal_warning;
  logic       last_of_run;
  logic       last_of_string;

  c_escape_sequence_decoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .octal_warning (octal_warning),
    .last_of_run   (last_of_run),
    .last_of_string(last_of_string)
  );

  char_beat_t          pending_chars[$];
  cesd_pkg::result_t   decoded_q[$];

  // decoder state
  cesd_pkg::mode_t esc_mode = cesd_pkg::MODE_PLAIN;
  int              digits = 0;
  logic [7:0]      accum = 8'd0;
  logic            warn_seen = 1'b0;

  int errors = 0;
  int beats_in = 0;
  int results_out = 0;
  int warnings_out = 0;
  int strings_in = 0;
  int cycles = 0;
  logic beat_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic cesd_pkg::result_t make_res(input logic [7:0] b, input logic w);
    cesd_pkg::result_t r;
    r.out_byte       = b;
    r.octal_warning  = w;
    r.last_of_run    = 1'b0;
    r.last_of_string = 1'b0;
    return r;
  endfunction

  function automatic void decode_beat(input logic [7:0] c, input logic eos);
    cesd_pkg::result_t run[$];
    logic       is_digit;
    logic       hex_ok;
    logic [3:0] hex_nib;
    logic       do_flush;
    logic       as_plain;
    logic [7:0] lit;
    is_digit = (c >= cesd_pkg::CH_0) && (c <= cesd_pkg::CH_9);
    hex_ok   = 1'b1;
    hex_nib  = c[3:0];
    if (c >= "a" && c <= "f") begin
      hex_nib = 4'(c - 8'h57);
    end else if (c >= "A" && c <= "F") begin
      hex_nib = 4'(c - 8'h37);
    end else if (!is_digit) begin
      hex_ok = 1'b0;
    end
    do_flush = 1'b0;
    as_plain = 1'b0;
    case (esc_mode)
      cesd_pkg::MODE_PLAIN: as_plain = 1'b1;
      cesd_pkg::MODE_ESC: begin
        esc_mode = cesd_pkg::MODE_PLAIN;
        if (c == cesd_pkg::CH_X) begin
          esc_mode = cesd_pkg::MODE_HEX;
          digits   = 0;
          accum    = 8'd0;
          do_flush = eos;
        end else if (is_digit) begin
          esc_mode  = cesd_pkg::MODE_OCT;
          digits    = 1;
          accum     = c - cesd_pkg::CH_0;
          warn_seen = c > cesd_pkg::CH_7;
          do_flush  = eos;
        end else begin
          case (c)
            cesd_pkg::CH_B: lit = cesd_pkg::CODE_BS;
            cesd_pkg::CH_F: lit = cesd_pkg::CODE_FF;
            cesd_pkg::CH_N: lit = cesd_pkg::CODE_LF;
            cesd_pkg::CH_R: lit = cesd_pkg::CODE_CR;
            cesd_pkg::CH_T: lit = cesd_pkg::CODE_TAB;
            default:        lit = c;
          endcase
          run = {run, make_res(lit, 1'b0)};
        end
      end
      cesd_pkg::MODE_HEX: begin
        if (hex_ok) begin
          accum = {accum[3:0], hex_nib};
          if (digits < 2) digits++;
          do_flush = eos;
        end else begin
          do_flush = 1'b1;
          as_plain = 1'b1;
        end
      end
      default: begin
        if (is_digit) begin
          accum = (accum << 3) + (c - cesd_pkg::CH_0);
          if (c > cesd_pkg::CH_7) warn_seen = 1'b1;
          digits++;
          do_flush = (digits >= 3) || eos;
        end else begin
          do_flush = 1'b1;
          as_plain = 1'b1;
        end
      end
    endcase
    if (do_flush) begin
      run = {run, make_res(accum, (esc_mode == cesd_pkg::MODE_OCT) ? warn_seen : 1'b0)};
      esc_mode  = cesd_pkg::MODE_PLAIN;
      digits    = 0;
      accum     = 8'd0;
      warn_seen = 1'b0;
    end
    if (as_plain) begin
      if (c == cesd_pkg::CH_BACKSLASH && !eos) esc_mode = cesd_pkg::MODE_ESC;
      else run = {run, make_res(c, 1'b0)};
    end
    if (run.size() > 0) begin
      run[run.size() - 1].last_of_run    = 1'b1;
      run[run.size() - 1].last_of_string = eos;
    end
    if (eos) begin
      esc_mode  = cesd_pkg::MODE_PLAIN;
      digits    = 0;
      accum     = 8'd0;
      warn_seen = 1'b0;
    end
    decoded_q = {decoded_q, run};
  endfunction

  task automatic add_beat(input logic [7:0] ch, input logic eos, input logic drain);
    char_beat_t b;
    b.ch    = ch;
    b.eos   = eos;
    b.drain = drain;
    pending_chars = {pending_chars, b};
  endtask

  task automatic queue_text(input string s, input logic eos, input logic drain);
    for (int i = 0; i < s.len(); i++) begin
      add_beat(s[i], eos && (i == s.len() - 1), drain && (i == 0));
    end
  endtask

  // one random piece of a string, mostly well-formed escapes
  task automatic add_piece(inout logic [7:0] str[$]);
    string      hexchars;
    int         kind;
    logic [7:0] ch;
    hexchars = "0123456789abcdefABCDEF";
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      ch = 8'($urandom_range(32, 126));
      if (ch == cesd_pkg::CH_BACKSLASH) ch = "_";
      str = {str, ch};
    end else if (kind < 30) begin
      ch = 8'($urandom_range(0, 255));
      str = {str, ch};
    end else if (kind < 50) begin
      str = {str, cesd_pkg::CH_BACKSLASH};
      case ($urandom_range(0, 6))
        0: ch = cesd_pkg::CH_B;
        1: ch = cesd_pkg::CH_F;
        2: ch = cesd_pkg::CH_N;
        3: ch = cesd_pkg::CH_R;
        4: ch = cesd_pkg::CH_T;
        5: ch = cesd_pkg::CH_BACKSLASH;
        default: ch = 8'($urandom_range(0, 255));
      endcase
      str = {str, ch};
    end else if (kind < 72) begin
      str = {str, cesd_pkg::CH_BACKSLASH};
      str = {str, cesd_pkg::CH_X};
      repeat ($urandom_range(0, 4)) begin
        ch = hexchars[$urandom_range(0, 21)];
        str = {str, ch};
      end
    end else if (kind < 95) begin
      str = {str, cesd_pkg::CH_BACKSLASH};
      repeat ($urandom_range(1, 4)) begin
        ch = ($urandom_range(0, 3) == 0) ? cesd_pkg::CH_0 + 8'($urandom_range(0, 9))
                                         : cesd_pkg::CH_0 + 8'($urandom_range(0, 7));
        str = {str, ch};
      end
    end else begin
      str = {str, cesd_pkg::CH_BACKSLASH};
    end
  endtask

  initial begin : stimulus
    logic [7:0] str[$];
    int         queued;
    // directed strings
    queue_text("\\b\\f\\n\\r\\t", 1'b0, 1'b0);
    queue_text("\\x1Ab", 1'b0, 1'b0);
    queue_text("\\1238", 1'b0, 1'b0);
    queue_text("\\x", 1'b1, 1'b0);
    queue_text("\\97", 1'b1, 1'b0);
    queue_text("\\", 1'b1, 1'b0);
    add_beat(cesd_pkg::CH_BACKSLASH, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);
    // random strings
    queued = 0;
    while (queued < 1700) begin
      str.delete();
      repeat ($urandom_range(1, 10)) add_piece(str);
      foreach (str[i]) begin
        add_beat(str[i], i == str.size() - 1, (queued == 0) || (queued % 450 == 0));
        queued++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (pending_chars.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d beats in %0d strings; checked %0d decoded bytes, %0d with octal warning.",
             beats_in, strings_in, results_out, warnings_out);
    if (errors == 0) begin
      $display("c_escape_sequence_decoder_top: match");
    end else begin
      $display("c_escape_sequence_decoder_top: mismatch");
    end
    $finish;
  end

  // accept input beats, check output beats
  always @(posedge clk) begin : monitor
    cesd_pkg::result_t exp_r;
    cycles++;
    beat_taken = !rst && in_valid && !in_stall;
    if (beat_taken) begin
      decode_beat(in_byte, end_of_string);
      beats_in++;
      if (end_of_string) strings_in++;
    end
    if (!rst && out_valid && !out_stall) begin
      results_out++;
      if (octal_warning) warnings_out++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %02h", out_byte);
        errors++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (out_byte !== exp_r.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp_r.out_byte, out_byte);
          errors++;
        end
        if (octal_warning !== exp_r.octal_warning) begin
          $error("octal_warning: expected %0b, got %0b", exp_r.octal_warning, octal_warning);
          errors++;
        end
        if (last_of_run !== exp_r.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", exp_r.last_of_run, last_of_run);
          errors++;
        end
        if (last_of_string !== exp_r.last_of_string) begin
          $error("last_of_string: expected %0b, got %0b", exp_r.last_of_string, last_of_string);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("c_escape_sequence_decoder_top: mismatch");
      $finish;
    end
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    logic       nv;
    logic [7:0] nb;
    logic       ne;
    nv = in_valid;
    nb = in_byte;
    ne = end_of_string;
    if (!rst) begin
      if (in_valid && beat_taken) nv = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].drain && decoded_q.size() != 0)) begin
          nv = 1'b1;
          nb = pending_chars[0].ch;
          ne = pending_chars[0].eos;
          void'(pending_chars.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid      <= nv;
    in_byte       <= nb;
    end_of_string <= ne;
  end

  // receiver: changing stall patterns plus long hold-offs
  int hold_left = 0;
  int holds_done = 0;
  int stall_kind = 0;
  int kind_left = 0;
  int phase = 0;

  always @(negedge clk) begin : receiver
    logic st;
    st = 1'b0;
    if (!rst) begin
      if (hold_left == 0 && holds_done < 2 && beats_in >= 500 * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else begin
        if (kind_left == 0) begin
          stall_kind = $urandom_range(0, 3);
          kind_left  = $urandom_range(20, 200);
        end else begin
          kind_left--;
        end
        phase++;
        case (stall_kind)
          0:       st = 1'b0;
          1:       st = ($urandom_range(0, 9) < 3);
          2:       st = (phase % 3 == 0);
          default: st = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
    out_stall <= st;
  end

endmodule
